@@ hw/rtl/eif_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// eif_pkg: shared types, constants and fixed-point helpers
// Word format, request layouts, register indexes and the saturating
// arithmetic used by the Euler interface flux pipeline.
// ----------------------------------------------------------------------------
package eif_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int IO_BITS   = 32;
  localparam int CFG_BITS  = 31;
  localparam int NUM_BITS  = WORD_BITS + FRAC_BITS;
  localparam int MAG_BITS  = 2 * WORD_BITS + 1;
  localparam int WIDE_BITS = 2 * WORD_BITS + 2;
  localparam int FLUX_LAT  = NUM_BITS + 7;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [WIDE_BITS-1:0] wide_t;
  typedef logic [MAG_BITS-1:0] mag_t;
  typedef logic signed [IO_BITS-1:0] io_t;
  typedef word_t [2:0] vec3_t;

  typedef struct packed {
    logic  sat;
    word_t val;
  } res_t;

  typedef struct packed {
    logic bad;
    logic sat;
  } flags_t;

  typedef struct packed {
    io_t left_density;
    io_t left_momentum;
    io_t left_energy;
    io_t right_density;
    io_t right_momentum;
    io_t right_energy;
  } in_t;

  typedef struct packed {
    io_t  mass_flux;
    io_t  momentum_flux;
    io_t  energy_flux;
    logic bad_density;
    logic saturated;
  } out_t;

  localparam logic [1:0] CFG_FLUX_SCHEME     = 2'd0;
  localparam logic [1:0] CFG_GAMMA_MINUS_ONE = 2'd1;
  localparam logic [1:0] CFG_DT_OVER_DX      = 2'd2;
  localparam logic [1:0] CFG_DX_OVER_DT      = 2'd3;

  localparam logic [1:0] SCHEME_LF    = 2'd0;
  localparam logic [1:0] SCHEME_RI    = 2'd1;
  localparam logic [1:0] SCHEME_FORCE = 2'd2;

  localparam mag_t  MAG_HALF = mag_t'(1) << (WORD_BITS - 1);
  localparam wide_t WMAX     = wide_t'(MAG_HALF - mag_t'(1));
  localparam wide_t WMIN     = -WMAX - wide_t'(1);

  function automatic res_t clampw(wide_t a);
    res_t r;
    r.sat = 1'b0;
    r.val = a[WORD_BITS-1:0];
    if (a > WMAX) begin
      r.sat = 1'b1;
      r.val = WMAX[WORD_BITS-1:0];
    end else if (a < WMIN) begin
      r.sat = 1'b1;
      r.val = WMIN[WORD_BITS-1:0];
    end
    return r;
  endfunction

  function automatic mag_t magw(wide_t a);
    wide_t t;
    t = (a < 0) ? -a : a;
    return t[MAG_BITS-1:0];
  endfunction

  function automatic res_t sres(mag_t m, logic neg);
    res_t r;
    mag_t lim;
    mag_t t;
    lim = neg ? MAG_HALF : MAG_HALF - mag_t'(1);
    r.sat = 1'b0;
    t = m;
    if (m > lim) begin
      r.sat = 1'b1;
      t = lim;
    end
    t = neg ? (~t + mag_t'(1)) : t;
    r.val = t[WORD_BITS-1:0];
    return r;
  endfunction

  function automatic res_t mulq(word_t a, word_t b);
    mag_t ma;
    mag_t mb;
    logic [WORD_BITS-1:0] ua;
    logic [WORD_BITS-1:0] ub;
    logic [2*WORD_BITS-1:0] pr;
    mag_t rnd;
    ma = magw(wide_t'(a));
    mb = magw(wide_t'(b));
    ua = ma[WORD_BITS-1:0];
    ub = mb[WORD_BITS-1:0];
    pr = ua * ub;
    rnd = (mag_t'(pr) + (mag_t'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return sres(rnd, a[WORD_BITS-1] ^ b[WORD_BITS-1]);
  endfunction

  function automatic wide_t halfw(wide_t a);
    mag_t m;
    m = (magw(a) + mag_t'(1)) >> 1;
    return (a < 0) ? -wide_t'(m) : wide_t'(m);
  endfunction

  function automatic word_t halfword(word_t a);
    wide_t t;
    t = halfw(wide_t'(a));
    return t[WORD_BITS-1:0];
  endfunction

  function automatic word_t avgw(word_t a, word_t b);
    wide_t t;
    t = halfw(wide_t'(a) + wide_t'(b));
    return t[WORD_BITS-1:0];
  endfunction

  function automatic res_t addq(word_t a, word_t b);
    return clampw(wide_t'(a) + wide_t'(b));
  endfunction

  function automatic res_t subq(word_t a, word_t b);
    return clampw(wide_t'(a) - wide_t'(b));
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/eif_flux.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// eif_flux: physical flux pipeline of one conserved state
// F(U) = (m, m*m/rho + p, (e + p)*m/rho), p = (gamma-1)*(e - m*m/(2*rho)),
// with three restoring dividers advancing one quotient bit per stage.
// ----------------------------------------------------------------------------
module eif_flux import eif_pkg::*; (
  input  logic   clk,
  input  logic   en,
  input  word_t  gm1,
  input  vec3_t  u,
  output vec3_t  f,
  output flags_t flags
);

  typedef struct packed {
    logic [NUM_BITS-1:0]  n;
    logic [WORD_BITS+1:0] r;
    logic [NUM_BITS-1:0]  q;
    logic [WORD_BITS:0]   d;
    logic                 neg;
  } dv_t;

  typedef dv_t [2:0] dv3_t;

  localparam logic [WORD_BITS-1:0] INT_LIM =
    WORD_BITS'(1) << (WORD_BITS - 1 - FRAC_BITS);

  function automatic dv_t div_init(word_t num, word_t rho, logic twice);
    dv_t  b;
    mag_t mn;
    mag_t md;
    mn = magw(wide_t'(num));
    md = magw(wide_t'(rho));
    b.n = {mn[WORD_BITS-1:0], {FRAC_BITS{1'b0}}};
    b.r = '0;
    b.q = '0;
    b.d = twice ? {md[WORD_BITS-1:0], 1'b0} : md[WORD_BITS:0];
    b.neg = num[WORD_BITS-1] ^ rho[WORD_BITS-1];
    return b;
  endfunction

  function automatic dv_t div_step(dv_t a);
    dv_t b;
    logic [WORD_BITS+1:0] rr;
    b = a;
    rr = {a.r[WORD_BITS:0], a.n[NUM_BITS-1]};
    b.n = a.n << 1;
    if (rr >= {1'b0, a.d}) begin
      b.r = rr - {1'b0, a.d};
      b.q = {a.q[NUM_BITS-2:0], 1'b1};
    end else begin
      b.r = rr;
      b.q = {a.q[NUM_BITS-2:0], 1'b0};
    end
    return b;
  endfunction

  function automatic res_t div_fin(dv_t a, logic zero);
    res_t r;
    logic rnd;
    rnd = {a.r, 1'b0} >= {2'b00, a.d};
    if (zero) begin
      r.sat = 1'b0;
      r.val = '0;
    end else if (a.q[NUM_BITS-1:FRAC_BITS] > INT_LIM) begin
      r = sres('1, a.neg);
    end else begin
      r = sres(mag_t'(a.q) + mag_t'(rnd), a.neg);
    end
    return r;
  endfunction

  word_t r1_mm, r1_m, r1_e, r1_rho;
  logic  r1_sat;

  dv3_t  dv     [NUM_BITS+1];
  word_t ds_e   [NUM_BITS+1];
  word_t ds_m   [NUM_BITS+1];
  logic  ds_sat [NUM_BITS+1];
  logic  ds_bad [NUM_BITS+1];
  logic  ds_zero[NUM_BITS+1];

  word_t fn_q2, fn_q1, fn_v, fn_e, fn_m;
  logic  fn_sat, fn_bad;
  word_t sb_s, sb_q1, sb_v, sb_e, sb_m;
  logic  sb_sat, sb_bad;
  word_t pp_p, pp_q1, pp_v, pp_e, pp_m;
  logic  pp_sat, pp_bad;
  word_t ad_ep, ad_o1, ad_v, ad_m;
  logic  ad_sat, ad_bad;

  res_t mm_next, q2_next, q1_next, v_next, s_next, p_next, ep_next, o1_next, o2_next;

  always_comb begin
    mm_next = mulq(u[1], u[1]);
    q2_next = div_fin(dv[NUM_BITS][0], ds_zero[NUM_BITS]);
    q1_next = div_fin(dv[NUM_BITS][1], ds_zero[NUM_BITS]);
    v_next  = div_fin(dv[NUM_BITS][2], ds_zero[NUM_BITS]);
    s_next  = subq(fn_e, fn_q2);
    p_next  = mulq(gm1, sb_s);
    ep_next = addq(pp_e, pp_p);
    o1_next = addq(pp_q1, pp_p);
    o2_next = mulq(ad_ep, ad_v);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_mm  <= mm_next.val;
      r1_sat <= mm_next.sat;
      r1_rho <= u[0];
      r1_m   <= u[1];
      r1_e   <= u[2];

      dv[0][0]   <= div_init(r1_mm, r1_rho, 1'b1);
      dv[0][1]   <= div_init(r1_mm, r1_rho, 1'b0);
      dv[0][2]   <= div_init(r1_m, r1_rho, 1'b0);
      ds_e[0]    <= r1_e;
      ds_m[0]    <= r1_m;
      ds_sat[0]  <= r1_sat;
      ds_bad[0]  <= r1_rho[WORD_BITS-1] || (r1_rho == '0);
      ds_zero[0] <= r1_rho == '0;
      for (int j = 1; j <= NUM_BITS; j++) begin
        for (int k = 0; k < 3; k++) begin
          dv[j][k] <= div_step(dv[j-1][k]);
        end
        ds_e[j]    <= ds_e[j-1];
        ds_m[j]    <= ds_m[j-1];
        ds_sat[j]  <= ds_sat[j-1];
        ds_bad[j]  <= ds_bad[j-1];
        ds_zero[j] <= ds_zero[j-1];
      end

      fn_q2  <= q2_next.val;
      fn_q1  <= q1_next.val;
      fn_v   <= v_next.val;
      fn_e   <= ds_e[NUM_BITS];
      fn_m   <= ds_m[NUM_BITS];
      fn_sat <= ds_sat[NUM_BITS] | q2_next.sat | q1_next.sat | v_next.sat;
      fn_bad <= ds_bad[NUM_BITS];

      sb_s   <= s_next.val;
      sb_q1  <= fn_q1;
      sb_v   <= fn_v;
      sb_e   <= fn_e;
      sb_m   <= fn_m;
      sb_sat <= fn_sat | s_next.sat;
      sb_bad <= fn_bad;

      pp_p   <= p_next.val;
      pp_q1  <= sb_q1;
      pp_v   <= sb_v;
      pp_e   <= sb_e;
      pp_m   <= sb_m;
      pp_sat <= sb_sat | p_next.sat;
      pp_bad <= sb_bad;

      ad_ep  <= ep_next.val;
      ad_o1  <= o1_next.val;
      ad_v   <= pp_v;
      ad_m   <= pp_m;
      ad_sat <= pp_sat | ep_next.sat | o1_next.sat;
      ad_bad <= pp_bad;

      f[0]      <= ad_m;
      f[1]      <= ad_o1;
      f[2]      <= o2_next.val;
      flags.sat <= ad_sat | o2_next.sat;
      flags.bad <= ad_bad;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/euler_interface_flux.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// euler_interface_flux: 1D Euler interface flux (Lax-Friedrichs/Richtmyer/FORCE)
// Streams interface requests and returns one saturated Q16.16 flux for each.
// ----------------------------------------------------------------------------
// One request enters per cycle and one result leaves per cycle unless the
// pipeline stalls. At Q16.16 the depth is set by the three physical-flux
// units, two in parallel for the cell states and one for the half step, each
// running restoring dividers that retire one quotient bit per stage. The
// pipeline stalls as a whole only when a result and one more behind it are
// waiting. Registers must be written only while no request is in flight;
// the block itself does not enforce this.
module euler_interface_flux import eif_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_t                 in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_t                out_data
);

  localparam int PIPE_LEN = 2 * FLUX_LAT + 4;
  localparam wide_t OUT_MAX = (wide_t'(1) <<< (IO_BITS - 1)) - wide_t'(1);
  localparam wide_t OUT_MIN = -OUT_MAX - wide_t'(1);

  logic [1:0]          flux_scheme;
  logic [CFG_BITS-1:0] gamma_minus_one;
  logic [CFG_BITS-1:0] dt_over_dx;
  logic [CFG_BITS-1:0] dx_over_dt;

  always_ff @(posedge clk) begin
    if (rst) begin
      flux_scheme     <= SCHEME_FORCE;
      gamma_minus_one <= CFG_BITS'(26214);
      dt_over_dx      <= CFG_BITS'(32768);
      dx_over_dt      <= CFG_BITS'(131072);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FLUX_SCHEME:     flux_scheme     <= cfg_data[1:0];
        CFG_GAMMA_MINUS_ONE: gamma_minus_one <= cfg_data;
        CFG_DT_OVER_DX:      dt_over_dx      <= cfg_data;
        CFG_DX_OVER_DT:      dx_over_dt      <= cfg_data;
        default: ;
      endcase
    end
  end

  res_t gm1_w, kx_w, kt_w;
  assign gm1_w = clampw(wide_t'(gamma_minus_one));
  assign kx_w  = clampw(wide_t'(dx_over_dt));
  assign kt_w  = clampw(wide_t'(dt_over_dx));

  logic en;
  logic leave;
  logic hold_valid;
  logic vld [PIPE_LEN];

  assign en       = !hold_valid;
  assign in_ready = en;
  assign leave    = en && vld[PIPE_LEN-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIPE_LEN; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 1; i < PIPE_LEN; i++) vld[i] <= vld[i-1];
    end
  end

  vec3_t s0_ul, s0_ur;
  logic  s0_sat;
  vec3_t s0_ul_next, s0_ur_next;
  logic  s0_sat_next;

  always_comb begin
    res_t t;
    io_t  fl [6];
    fl[0] = in_data.left_density;
    fl[1] = in_data.left_momentum;
    fl[2] = in_data.left_energy;
    fl[3] = in_data.right_density;
    fl[4] = in_data.right_momentum;
    fl[5] = in_data.right_energy;
    s0_sat_next = 1'b0;
    for (int k = 0; k < 3; k++) begin
      t = clampw(wide_t'(fl[k]));
      s0_ul_next[k] = t.val;
      s0_sat_next = s0_sat_next | t.sat;
      t = clampw(wide_t'(fl[k+3]));
      s0_ur_next[k] = t.val;
      s0_sat_next = s0_sat_next | t.sat;
    end
  end

  vec3_t  fx_l, fx_r, fx_h;
  flags_t fg_l, fg_r, fg_h;

  eif_flux u_flux_left (
    .clk(clk), .en(en), .gm1(gm1_w.val), .u(s0_ul), .f(fx_l), .flags(fg_l)
  );

  eif_flux u_flux_right (
    .clk(clk), .en(en), .gm1(gm1_w.val), .u(s0_ur), .f(fx_r), .flags(fg_r)
  );

  vec3_t da_ul  [FLUX_LAT];
  vec3_t da_ur  [FLUX_LAT];
  logic  da_sat [FLUX_LAT];

  vec3_t  a_dl, a_df, a_au, a_af;
  flags_t a_f0;
  logic   a_sl, a_sr;
  vec3_t  a_dl_next, a_df_next, a_au_next, a_af_next;
  logic   a_sl_next, a_sr_next;

  always_comb begin
    res_t t;
    a_sl_next = 1'b0;
    a_sr_next = 1'b0;
    for (int k = 0; k < 3; k++) begin
      t = subq(da_ul[FLUX_LAT-1][k], da_ur[FLUX_LAT-1][k]);
      a_dl_next[k] = t.val;
      a_sl_next = a_sl_next | t.sat;
      t = subq(fx_r[k], fx_l[k]);
      a_df_next[k] = t.val;
      a_sr_next = a_sr_next | t.sat;
      a_au_next[k] = avgw(da_ul[FLUX_LAT-1][k], da_ur[FLUX_LAT-1][k]);
      a_af_next[k] = avgw(fx_l[k], fx_r[k]);
    end
  end

  vec3_t  b_ml, b_mr, b_au, b_af;
  flags_t b_f0;
  logic   b_sl, b_sr;
  vec3_t  b_ml_next, b_mr_next;
  logic   b_sl_next, b_sr_next;

  always_comb begin
    res_t t;
    b_sl_next = a_sl;
    b_sr_next = a_sr;
    for (int k = 0; k < 3; k++) begin
      t = mulq(kx_w.val, a_dl[k]);
      b_ml_next[k] = t.val;
      b_sl_next = b_sl_next | t.sat;
      t = mulq(kt_w.val, a_df[k]);
      b_mr_next[k] = t.val;
      b_sr_next = b_sr_next | t.sat;
    end
  end

  vec3_t  c_lf, c_uh;
  flags_t c_f0;
  logic   c_sl, c_sr;
  vec3_t  c_lf_next, c_uh_next;
  logic   c_sl_next, c_sr_next;

  always_comb begin
    res_t t;
    c_sl_next = b_sl;
    c_sr_next = b_sr;
    for (int k = 0; k < 3; k++) begin
      t = addq(halfword(b_ml[k]), b_af[k]);
      c_lf_next[k] = t.val;
      c_sl_next = c_sl_next | t.sat;
      t = subq(b_au[k], halfword(b_mr[k]));
      c_uh_next[k] = t.val;
      c_sr_next = c_sr_next | t.sat;
    end
  end

  eif_flux u_flux_half (
    .clk(clk), .en(en), .gm1(gm1_w.val), .u(c_uh), .f(fx_h), .flags(fg_h)
  );

  vec3_t  dc_lf [FLUX_LAT];
  flags_t dc_f0 [FLUX_LAT];
  logic   dc_sl [FLUX_LAT];
  logic   dc_sr [FLUX_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      s0_ul  <= s0_ul_next;
      s0_ur  <= s0_ur_next;
      s0_sat <= s0_sat_next;

      da_ul[0]  <= s0_ul;
      da_ur[0]  <= s0_ur;
      da_sat[0] <= s0_sat;
      for (int i = 1; i < FLUX_LAT; i++) begin
        da_ul[i]  <= da_ul[i-1];
        da_ur[i]  <= da_ur[i-1];
        da_sat[i] <= da_sat[i-1];
      end

      a_dl     <= a_dl_next;
      a_df     <= a_df_next;
      a_au     <= a_au_next;
      a_af     <= a_af_next;
      a_sl     <= a_sl_next;
      a_sr     <= a_sr_next;
      a_f0.bad <= fg_l.bad | fg_r.bad;
      a_f0.sat <= da_sat[FLUX_LAT-1] | fg_l.sat | fg_r.sat;

      b_ml <= b_ml_next;
      b_mr <= b_mr_next;
      b_au <= a_au;
      b_af <= a_af;
      b_sl <= b_sl_next;
      b_sr <= b_sr_next;
      b_f0 <= a_f0;

      c_lf <= c_lf_next;
      c_uh <= c_uh_next;
      c_sl <= c_sl_next;
      c_sr <= c_sr_next;
      c_f0 <= b_f0;

      dc_lf[0] <= c_lf;
      dc_f0[0] <= c_f0;
      dc_sl[0] <= c_sl;
      dc_sr[0] <= c_sr;
      for (int i = 1; i < FLUX_LAT; i++) begin
        dc_lf[i] <= dc_lf[i-1];
        dc_f0[i] <= dc_f0[i-1];
        dc_sl[i] <= dc_sl[i-1];
        dc_sr[i] <= dc_sr[i-1];
      end
    end
  end

  out_t res;

  always_comb begin
    vec3_t sel;
    io_t   ov [3];
    logic  use_lf, use_ri, osat;
    wide_t w;
    case (flux_scheme)
      SCHEME_LF: begin
        use_lf = 1'b1;
        use_ri = 1'b0;
      end
      SCHEME_RI: begin
        use_lf = 1'b0;
        use_ri = 1'b1;
      end
      default: begin
        use_lf = 1'b1;
        use_ri = 1'b1;
      end
    endcase
    osat = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (!use_ri) sel[k] = dc_lf[FLUX_LAT-1][k];
      else if (!use_lf) sel[k] = fx_h[k];
      else sel[k] = avgw(dc_lf[FLUX_LAT-1][k], fx_h[k]);
      w = wide_t'(sel[k]);
      if (w > OUT_MAX) begin
        w = OUT_MAX;
        osat = 1'b1;
      end else if (w < OUT_MIN) begin
        w = OUT_MIN;
        osat = 1'b1;
      end
      ov[k] = w[IO_BITS-1:0];
    end
    res.mass_flux     = ov[0];
    res.momentum_flux = ov[1];
    res.energy_flux   = ov[2];
    res.bad_density   = dc_f0[FLUX_LAT-1].bad | (use_ri & fg_h.bad);
    res.saturated     = dc_f0[FLUX_LAT-1].sat | gm1_w.sat | osat
                      | (use_lf & (dc_sl[FLUX_LAT-1] | kx_w.sat))
                      | (use_ri & (dc_sr[FLUX_LAT-1] | kt_w.sat | fg_h.sat));
  end

  out_t hold;
  logic out_free;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else if (out_free) begin
      if (hold_valid) begin
        out_valid  <= 1'b1;
        hold_valid <= 1'b0;
      end else begin
        out_valid <= leave;
      end
    end else if (leave) begin
      hold_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (hold_valid) out_data <= hold;
      else if (leave) out_data <= res;
    end else if (leave) begin
      hold <= res;
    end
  end

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the Euler interface flux pipeline
// Streams cell-pair requests through random and back-to-back handshakes.
// A bit-exact fixed-point flux predictor checks every result in order.
// Several scheme and coefficient settings are swept between drained phases.
// ----------------------------------------------------------------------------
module tb_top import eif_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;
  localparam int     DRAIN_CYCLES = 2 * FLUX_LAT + 20;
  localparam int     STALL_CYCLES = 400;
  localparam int     WATCHDOG_LIMIT = 4000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_write = 1'b0;
  logic [1:0]          cfg_index = CFG_FLUX_SCHEME;
  logic [CFG_BITS-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_t                 in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_t                out_data;

  euler_interface_flux dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [1:0]          scheme_q = SCHEME_FORCE;
  logic [CFG_BITS-1:0] gm1_q = 31'd26214;
  logic [CFG_BITS-1:0] dtdx_q = 31'd32768;
  logic [CFG_BITS-1:0] dxdt_q = 31'd131072;

  in_t  pending_req[$];
  out_t flux_expected[$];
  int   err_cnt = 0;
  bit   burst = 1'b0;
  bit   stall_req = 1'b0;
  bit   stall_taken = 1'b0;
  int   tx_gap = 0;
  int   rx_gap = 0;
  int   rx_hold = 0;
  int   idle_cycles = 0;

  function automatic longint sat_word(longint a, inout bit s);
    if (a > QMAX) begin
      s = 1'b1;
      return QMAX;
    end
    if (a < QMIN) begin
      s = 1'b1;
      return QMIN;
    end
    return a;
  endfunction

  function automatic longint unsigned mag64(longint a);
    return a < 0 ? longint'(-a) : a;
  endfunction

  function automatic longint sign_sat(longint unsigned m, bit neg, inout bit s);
    longint unsigned lim;
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    if (m > lim) begin
      s = 1'b1;
      m = lim;
    end
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint half_away(longint a);
    longint unsigned m;
    m = (mag64(a) + 1) >> 1;
    return a < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint q_mul(longint a, longint b, inout bit s);
    longint unsigned p;
    p = (mag64(a) * mag64(b) + 64'd32768) >> FRAC_BITS;
    return sign_sat(p, (a < 0) != (b < 0), s);
  endfunction

  function automatic longint q_div(longint a, longint rho, bit twice, inout bit bad,
                                   inout bit s);
    longint unsigned n, d, q, r;
    bit neg;
    n = mag64(a);
    d = mag64(rho);
    neg = (a < 0) != (rho < 0);
    if (rho <= 0) bad = 1'b1;
    if (rho == 0) return 0;
    if (twice) d = d << 1;
    q = n / d;
    r = n % d;
    if (q > 64'd32768) return sign_sat(64'hFFFF_FFFF_FFFF_FFFF, neg, s);
    for (int i = 0; i < FRAC_BITS; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 1;
      end
    end
    if (r >= d - r) q = q + 1;
    return sign_sat(q, neg, s);
  endfunction

  function automatic void cell_flux(input longint rho, input longint m, input longint e,
                                    input longint gm1, output longint f0,
                                    output longint f1, output longint f2,
                                    inout bit bad, inout bit s);
    longint mm, p;
    mm = q_mul(m, m, s);
    p = q_mul(gm1, sat_word(e - q_div(mm, rho, 1'b1, bad, s), s), s);
    f0 = m;
    f1 = sat_word(q_div(mm, rho, 1'b0, bad, s) + p, s);
    f2 = q_mul(sat_word(e + p, s), q_div(m, rho, 1'b0, bad, s), s);
  endfunction

  function automatic out_t predict_flux(in_t x);
    longint ul[3], ur[3], fl[3], fr[3], uh[3], lf[3], ri[3], res[3];
    longint gm1, kx, kt;
    bit b0, s0, bl, sl, br, sr;
    out_t o;
    b0 = 0; s0 = 0; bl = 0; sl = 0; br = 0; sr = 0;
    ul[0] = longint'(x.left_density);
    ul[1] = longint'(x.left_momentum);
    ul[2] = longint'(x.left_energy);
    ur[0] = longint'(x.right_density);
    ur[1] = longint'(x.right_momentum);
    ur[2] = longint'(x.right_energy);
    gm1 = longint'({33'd0, gm1_q});
    kx = longint'({33'd0, dxdt_q});
    kt = longint'({33'd0, dtdx_q});
    cell_flux(ul[0], ul[1], ul[2], gm1, fl[0], fl[1], fl[2], b0, s0);
    cell_flux(ur[0], ur[1], ur[2], gm1, fr[0], fr[1], fr[2], b0, s0);
    for (int k = 0; k < 3; k++) begin
      lf[k] = sat_word(half_away(q_mul(kx, sat_word(ul[k] - ur[k], sl), sl))
                       + half_away(fl[k] + fr[k]), sl);
      uh[k] = sat_word(half_away(ul[k] + ur[k])
                       - half_away(q_mul(kt, sat_word(fr[k] - fl[k], sr), sr)), sr);
    end
    cell_flux(uh[0], uh[1], uh[2], gm1, ri[0], ri[1], ri[2], br, sr);
    for (int k = 0; k < 3; k++) begin
      if (scheme_q == SCHEME_LF) res[k] = lf[k];
      else if (scheme_q == SCHEME_RI) res[k] = ri[k];
      else res[k] = half_away(lf[k] + ri[k]);
    end
    if (scheme_q != SCHEME_RI) begin
      b0 |= bl;
      s0 |= sl;
    end
    if (scheme_q != SCHEME_LF) begin
      b0 |= br;
      s0 |= sr;
    end
    o.mass_flux = io_t'(res[0]);
    o.momentum_flux = io_t'(res[1]);
    o.energy_flux = io_t'(res[2]);
    o.bad_density = b0;
    o.saturated = s0;
    return o;
  endfunction

  function automatic in_t cell_pair(int lr, int lm, int le, int rr, int rm, int re);
    in_t x;
    x.left_density = lr;
    x.left_momentum = lm;
    x.left_energy = le;
    x.right_density = rr;
    x.right_momentum = rm;
    x.right_energy = re;
    return x;
  endfunction

  function automatic int gas_density();
    int r;
    r = $urandom_range(99);
    if (r < 4) return 0;
    if (r < 8) return -int'($urandom_range(1, 32'h7FFF_FFFF));
    if (r < 15) return $urandom_range(1, 32'h0000_0400);
    if (r < 22) return $urandom_range(32'h0010_0000, 32'h7FFF_FFFF);
    return $urandom_range(32'h0000_1000, 32'h0014_0000);
  endfunction

  function automatic in_t random_pair();
    int lr, rr;
    if ($urandom_range(99) < 25)
      return cell_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    lr = gas_density();
    rr = gas_density();
    return cell_pair(lr, int'($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000,
                     $urandom_range(0, 32'h0032_0000),
                     rr, int'($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000,
                     $urandom_range(0, 32'h0032_0000));
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) flux_expected.push_back(predict_flux(in_data));
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_req.size() > 0) begin
          in_data <= pending_req.pop_front();
          in_valid <= 1'b1;
          tx_gap <= burst ? 0 : $urandom_range(0, 10);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (flux_expected.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("unexpected result %h", out_data);
        end else begin
          want = flux_expected.pop_front();
          if (out_data !== want) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("mismatch: expected m=%h p=%h e=%h b=%b s=%b got m=%h p=%h e=%h b=%b s=%b",
                       want.mass_flux, want.momentum_flux, want.energy_flux,
                       want.bad_density, want.saturated, out_data.mass_flux,
                       out_data.momentum_flux, out_data.energy_flux,
                       out_data.bad_density, out_data.saturated);
          end
        end
      end
      if (stall_req && !stall_taken) begin
        stall_taken <= 1'b1;
        rx_hold <= STALL_CYCLES;
        out_ready <= 1'b0;
      end else if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
        out_ready <= 1'b0;
      end else if (out_valid && out_ready) begin
        rx_gap = burst ? 0 : $urandom_range(0, 10);
        out_ready <= (rx_gap == 0);
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= (rx_gap == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [CFG_BITS-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_FLUX_SCHEME:     scheme_q = val[1:0];
      CFG_GAMMA_MINUS_ONE: gm1_q = val;
      CFG_DT_OVER_DX:      dtdx_q = val;
      default:             dxdt_q = val;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic drain();
    while (pending_req.size() > 0 || in_valid) @(posedge clk);
    while (flux_expected.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic setup(logic [1:0] sch, logic [CFG_BITS-1:0] g, logic [CFG_BITS-1:0] t,
                       logic [CFG_BITS-1:0] x);
    drain();
    write_reg(CFG_FLUX_SCHEME, {29'($urandom_range(0, 32'h1FFF_FFFF)), sch});
    write_reg(CFG_GAMMA_MINUS_ONE, g);
    write_reg(CFG_DT_OVER_DX, t);
    write_reg(CFG_DX_OVER_DT, x);
  endtask

  task automatic queue_random(int n);
    repeat (n) pending_req.push_back(random_pair());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    burst = 1'b1;
    pending_req.push_back(cell_pair(0, 0, 0, 0, 0, 0));
    pending_req.push_back(cell_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    pending_req.push_back(cell_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    pending_req.push_back(cell_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                    32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    pending_req.push_back(cell_pair(32'h0001_0000, 0, 32'h0002_8000,
                                    32'h0000_2000, 0, 32'h0000_4000));
    pending_req.push_back(cell_pair(32'h0001_0000, 32'h0001_0000, 32'h0002_8000,
                                    32'h0001_0000, 32'h0001_0000, 32'h0002_8000));
    pending_req.push_back(cell_pair(0, 32'h0001_0000, 32'h0001_0000,
                                    32'h0001_0000, 0, 32'h0001_0000));
    pending_req.push_back(cell_pair(32'h0001_0000, 0, 32'h0001_0000,
                                    -32'sh0001_0000, 32'h0002_0000, 32'h0001_0000));
    pending_req.push_back(cell_pair(1, 32'h0100_0000, 32'h0001_0000,
                                    1, -32'sh0100_0000, 32'h0001_0000));
    pending_req.push_back(cell_pair(-1, -32'sh0000_8000, -32'sh0001_0000,
                                    32'h0000_0001, 32'h0000_8000, 32'h7FFF_FFFF));
    pending_req.push_back(cell_pair(32'h0003_0000, -32'sh0002_0000, 32'h0005_0000,
                                    32'h0000_8000, 32'h0000_4000, 32'h0000_C000));
    pending_req.push_back(cell_pair(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                                    32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
    queue_random(200);
    drain();
    burst = 1'b0;
    setup(SCHEME_LF, 31'd26214, 31'd32768, 31'd131072);
    queue_random(250);
    setup(SCHEME_RI, 31'd26214, 31'd32768, 31'd131072);
    stall_req = 1'b1;
    queue_random(250);
    setup(2'd3, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    queue_random(150);
    setup(SCHEME_FORCE, 31'd0, 31'd0, 31'd0);
    queue_random(150);
    for (int ph = 0; ph < 4; ph++) begin
      setup(2'($urandom_range(0, 3)), CFG_BITS'($urandom_range(0, 32'h0002_0000)),
            CFG_BITS'($urandom_range(0, 32'h0002_0000)),
            CFG_BITS'($urandom_range(0, 32'h0008_0000)));
      burst = (ph == 2);
      queue_random(200);
    end
    while (pending_req.size() > 0 || in_valid) @(posedge clk);
    while (flux_expected.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0 && flux_expected.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
